// File: rtl/core/line_rasterizer_core_assert.svh
// Assertion macros for the line rasteriser. Simulation builds get the checks,
// synthesis builds get empty bodies.
`ifndef LINE_RASTERIZER_CORE_ASSERT_SVH
`define LINE_RASTERIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is asserted.
`define LR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LR_ASSERT(label, clk, rst_n, prop, msg)
`define LR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/core/lr_pkg.sv
package lr_pkg;

  localparam int unsigned XBitsDef      = 9;
  localparam int unsigned YBitsDef      = 8;
  localparam int unsigned RowShiftDef   = 10;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned ColourW       = 16;
  localparam logic [AddrW-1:0] FrameBaseReset = 32'hC800_0000;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  // Per-line flags kept alongside the coordinate registers.
  typedef struct packed {
    logic steep;
    logic minor_down;
  } lr_flags_t;

endpackage

// File: rtl/core/lr_datapath.sv
module lr_datapath #(
  parameter int unsigned XBits    = lr_pkg::XBitsDef,
  parameter int unsigned YBits    = lr_pkg::YBitsDef,
  parameter int unsigned RowShift = lr_pkg::RowShiftDef,
  localparam int unsigned CBits   = (XBits > YBits) ? XBits : YBits,
  localparam int unsigned EBits   = CBits + 2
) (
  input  logic                        start_i,
  input  logic [XBits-1:0]            start_x_i,
  input  logic [YBits-1:0]            start_y_i,
  input  logic [XBits-1:0]            end_x_i,
  input  logic [YBits-1:0]            end_y_i,
  input  logic [lr_pkg::ColourW-1:0]  line_colour_i,
  input  logic [lr_pkg::AddrW-1:0]    frame_base_i,
  // current line state
  input  lr_pkg::lr_flags_t           flags_i,
  input  logic [CBits-1:0]            major_pos_i,
  input  logic [CBits-1:0]            major_end_i,
  input  logic [CBits-1:0]            minor_pos_i,
  input  logic [CBits-1:0]            delta_major_i,
  input  logic [CBits-1:0]            delta_minor_i,
  input  logic signed [EBits-1:0]     error_i,
  input  logic [lr_pkg::ColourW-1:0]  colour_i,
  // line state after this pixel
  output lr_pkg::lr_flags_t           flags_o,
  output logic                        active_o,
  output logic [CBits-1:0]            major_pos_o,
  output logic [CBits-1:0]            major_end_o,
  output logic [CBits-1:0]            minor_pos_o,
  output logic [CBits-1:0]            delta_major_o,
  output logic [CBits-1:0]            delta_minor_o,
  output logic signed [EBits-1:0]     error_o,
  output logic [lr_pkg::ColourW-1:0]  colour_o,
  // pixel
  output logic [XBits-1:0]            pixel_x_o,
  output logic [YBits-1:0]            pixel_y_o,
  output logic [lr_pkg::AddrW-1:0]    pixel_address_o,
  output logic                        last_pixel_o
);

  logic [CBits-1:0]    sx, sy, ex, ey;
  logic [CBits:0]      diff_x, diff_y;
  logic [CBits-1:0]    mag_x, mag_y;
  logic                new_steep, new_swap;
  logic [CBits-1:0]    a0, a1, b0, b1;
  logic [CBits-1:0]    new_major, new_end, new_minor, new_minor_end;
  logic [CBits-1:0]    new_dmaj, new_dmin;
  logic signed [EBits-1:0] new_error;

  lr_pkg::lr_flags_t       cur_flags;
  logic [CBits-1:0]        cur_major, cur_end, cur_minor, cur_dmaj, cur_dmin;
  logic signed [EBits-1:0] cur_error, err_add;

  // Set-up for a new line: steepness, axis swap and endpoint ordering.
  always_comb begin
    sx = CBits'(start_x_i);
    sy = CBits'(start_y_i);
    ex = CBits'(end_x_i);
    ey = CBits'(end_y_i);
    diff_x = {1'b0, ex} - {1'b0, sx};
    diff_y = {1'b0, ey} - {1'b0, sy};
    mag_x  = diff_x[CBits] ? CBits'(~diff_x + 1'b1) : diff_x[CBits-1:0];
    mag_y  = diff_y[CBits] ? CBits'(~diff_y + 1'b1) : diff_y[CBits-1:0];
    new_steep = mag_y > mag_x;
    a0 = new_steep ? sy : sx;
    a1 = new_steep ? ey : ex;
    b0 = new_steep ? sx : sy;
    b1 = new_steep ? ex : ey;
    new_swap      = a0 > a1;
    new_major     = new_swap ? a1 : a0;
    new_end       = new_swap ? a0 : a1;
    new_minor     = new_swap ? b1 : b0;
    new_minor_end = new_swap ? b0 : b1;
    new_dmaj  = new_steep ? mag_y : mag_x;
    new_dmin  = new_steep ? mag_x : mag_y;
    new_error = -$signed({2'b00, new_dmaj >> 1});
  end

  always_comb begin
    if (start_i) begin
      cur_flags.steep      = new_steep;
      cur_flags.minor_down = !(new_minor < new_minor_end);
      cur_major = new_major;
      cur_end   = new_end;
      cur_minor = new_minor;
      cur_dmaj  = new_dmaj;
      cur_dmin  = new_dmin;
      cur_error = new_error;
      colour_o  = line_colour_i;
    end else begin
      cur_flags = flags_i;
      cur_major = major_pos_i;
      cur_end   = major_end_i;
      cur_minor = minor_pos_i;
      cur_dmaj  = delta_major_i;
      cur_dmin  = delta_minor_i;
      cur_error = error_i;
      colour_o  = colour_i;
    end
  end

  always_comb begin
    pixel_x_o = cur_flags.steep ? cur_minor[XBits-1:0] : cur_major[XBits-1:0];
    pixel_y_o = cur_flags.steep ? cur_major[YBits-1:0] : cur_minor[YBits-1:0];
    pixel_address_o = frame_base_i
                    + (lr_pkg::AddrW'(pixel_y_o) << RowShift)
                    + (lr_pkg::AddrW'(pixel_x_o) << 1);
    last_pixel_o = cur_major == cur_end;
  end

  // One Bresenham step.
  always_comb begin
    err_add       = cur_error + $signed({2'b00, cur_dmin});
    flags_o       = cur_flags;
    active_o      = !last_pixel_o;
    major_pos_o   = cur_major + 1'b1;
    major_end_o   = cur_end;
    delta_major_o = cur_dmaj;
    delta_minor_o = cur_dmin;
    if (!err_add[EBits-1]) begin
      minor_pos_o = cur_flags.minor_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
      error_o     = err_add - $signed({2'b00, cur_dmaj});
    end else begin
      minor_pos_o = cur_minor;
      error_o     = err_add;
    end
  end

endmodule

// File: rtl/core/line_rasterizer_core.sv
// Channel   | Direction | Payload
// s_axis    | in        | tuser: mode; tdata: start/end points and colour
// m_axis    | out       | tdata: pixel x, y, address, colour; tlast: last pixel
// cfg       | in        | cfg_data_i: frame base address
//
// Each request is handled in a single pass: a start, or a step while a line is
// active, goes through set-up and stepping logic into the output or skid register.
// One request per cycle is taken while the skid register is empty; the skid
// register holds a pixel that arrives while the output register is stalled.
// Reset clears the line-active flag and both valid flags, and loads the reset frame base.
// A stalled output lowers s_axis_tready only once the skid register holds a pixel.
`include "line_rasterizer_core_assert.svh"

module line_rasterizer_core #(
  parameter int unsigned XBits    = lr_pkg::XBitsDef,
  parameter int unsigned YBits    = lr_pkg::YBitsDef,
  parameter int unsigned RowShift = lr_pkg::RowShiftDef,
  localparam int unsigned InRaw   = 2 * XBits + 2 * YBits + lr_pkg::ColourW,
  localparam int unsigned InW     = ((InRaw + 7) / 8) * 8,
  localparam int unsigned OutRaw  = XBits + YBits + lr_pkg::AddrW + lr_pkg::ColourW,
  localparam int unsigned OutW    = ((OutRaw + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: start_x, start_y, end_x, end_y, line_colour, zero padding
  input  logic [InW-1:0]             s_axis_tdata,
  // tuser: mode
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_address, pixel_colour, zero padding
  output logic [OutW-1:0]            m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lr_pkg::AddrW-1:0]   cfg_data_i
);

  localparam int unsigned CBits = (XBits > YBits) ? XBits : YBits;
  localparam int unsigned EBits = CBits + 2;
  localparam int unsigned OffSy = XBits;
  localparam int unsigned OffEx = XBits + YBits;
  localparam int unsigned OffEy = 2 * XBits + YBits;
  localparam int unsigned OffC  = 2 * XBits + 2 * YBits;
  localparam int unsigned BufW  = OutRaw + 1;

  logic [lr_pkg::AddrW-1:0]   frame_base_q;
  logic                       active_q;
  lr_pkg::lr_flags_t          flags_q, flags_d;
  logic                       active_d;
  logic [CBits-1:0]           major_pos_q, major_pos_d, major_end_q, major_end_d;
  logic [CBits-1:0]           minor_pos_q, minor_pos_d;
  logic [CBits-1:0]           dmaj_q, dmaj_d, dmin_q, dmin_d;
  logic signed [EBits-1:0]    error_q, error_d;
  logic [lr_pkg::ColourW-1:0] colour_q, colour_d;

  logic [XBits-1:0]           pix_x;
  logic [YBits-1:0]           pix_y;
  logic [lr_pkg::AddrW-1:0]   pix_addr;
  logic                       pix_last;

  logic                       in_acc, is_start, push, pop;
  logic [BufW-1:0]            new_buf, out_buf_q, skid_buf_q;
  logic                       out_valid_q, skid_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= lr_pkg::FrameBaseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_base_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_start = lr_pkg::mode_e'(s_axis_tuser) == lr_pkg::MODE_START;
  assign push     = in_acc && (is_start || active_q);
  assign pop      = out_valid_q && m_axis_tready;

  lr_datapath #(
    .XBits    (XBits),
    .YBits    (YBits),
    .RowShift (RowShift)
  ) u_lr_datapath (
    .start_i         (is_start),
    .start_x_i       (s_axis_tdata[OffSy-1:0]),
    .start_y_i       (s_axis_tdata[OffEx-1:OffSy]),
    .end_x_i         (s_axis_tdata[OffEy-1:OffEx]),
    .end_y_i         (s_axis_tdata[OffC-1:OffEy]),
    .line_colour_i   (s_axis_tdata[InRaw-1:OffC]),
    .frame_base_i    (frame_base_q),
    .flags_i         (flags_q),
    .major_pos_i     (major_pos_q),
    .major_end_i     (major_end_q),
    .minor_pos_i     (minor_pos_q),
    .delta_major_i   (dmaj_q),
    .delta_minor_i   (dmin_q),
    .error_i         (error_q),
    .colour_i        (colour_q),
    .flags_o         (flags_d),
    .active_o        (active_d),
    .major_pos_o     (major_pos_d),
    .major_end_o     (major_end_d),
    .minor_pos_o     (minor_pos_d),
    .delta_major_o   (dmaj_d),
    .delta_minor_o   (dmin_d),
    .error_o         (error_d),
    .colour_o        (colour_d),
    .pixel_x_o       (pix_x),
    .pixel_y_o       (pix_y),
    .pixel_address_o (pix_addr),
    .last_pixel_o    (pix_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (push) begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      flags_q     <= flags_d;
      major_pos_q <= major_pos_d;
      major_end_q <= major_end_d;
      minor_pos_q <= minor_pos_d;
      dmaj_q      <= dmaj_d;
      dmin_q      <= dmin_d;
      error_q     <= error_d;
      colour_q    <= colour_d;
    end
  end

  assign new_buf = {pix_last, colour_d, pix_addr, pix_y, pix_x};

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_buf_q <= skid_buf_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_buf_q <= new_buf;
      end else begin
        skid_buf_q <= new_buf;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_buf_q[OutRaw-1:0]);
  assign m_axis_tlast  = out_buf_q[OutRaw];

  `LR_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid full while output register empty")
  `LR_ASSERT(a_skid_on_stall, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready), "skid filled without a stalled output")
  `LR_ASSERT(a_last_ends_line, clk_i, rst_ni, (push && pix_last) |=> !active_q, "line still active after its last pixel")
  `LR_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> (!out_valid_q && !skid_valid_q && !active_q), "state not idle in reset")

endmodule
